>>> hdl/aging_priority_preemptive_scheduler_defines.svh
// assertion helpers for the scheduler; expects clk and rst_n in scope
`ifndef AGING_PRIORITY_PREEMPTIVE_SCHEDULER_DEFINES_SVH
`define AGING_PRIORITY_PREEMPTIVE_SCHEDULER_DEFINES_SVH
`ifndef SYNTH
`define APS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define APS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define APS_ASSERT_IMP(label, ante, cons, msg)
`define APS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> hdl/aps_pkg.sv
`default_nettype none
package aps_pkg;
  localparam int KEY_W  = 34;
  localparam int LEFT_W = 16;
  localparam int PRIO_W = 16;
  localparam int TICK_W = 32;
  localparam int SUM_W  = 40;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [LEFT_W-1:0] left;
  } entry_t;

  typedef struct packed {
    logic              vld;
    logic [KEY_W-1:0]  key;
    logic [LEFT_W-1:0] left;
  } best_t;
endpackage
`default_nettype wire

>>> hdl/aps_cell.sv
`default_nettype none
module aps_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            live,
  input  wire logic            wr_en,
  input  wire aps_pkg::entry_t wr_data,
  input  wire aps_pkg::best_t  best_in,
  input  wire logic [IDX_W-1:0] best_idx_in,
  output aps_pkg::entry_t      ent,
  output aps_pkg::best_t       best_out,
  output logic [IDX_W-1:0]     best_idx_out
);
  import aps_pkg::*;

  entry_t            ent_r;
  best_t             best_r, best_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // strict compare keeps the earlier entry on a tie
  always_comb begin
    if (live && (!best_in.vld || ent_r.key < best_in.key)) begin
      best_nxt = '{vld: 1'b1, key: ent_r.key, left: ent_r.left};
      idx_nxt  = IDX_W'(CELL_IDX);
    end else begin
      best_nxt = best_in;
      idx_nxt  = best_idx_in;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r <= wr_data;
    end
    idx_r <= idx_nxt;
    if (!rst_n) begin
      best_r <= '0;
    end else begin
      best_r <= best_nxt;
    end
  end

  assign ent          = ent_r;
  assign best_out     = best_r;
  assign best_idx_out = idx_r;
endmodule
`default_nettype wire

>>> hdl/aging_priority_preemptive_scheduler.sv
// Aging preemptive priority scheduler, one scheduler tick per input transfer.
// Input channel (in_valid/in_ready): one tick, optionally carrying an arriving
// job (priority, burst) and the arrivals_finished flag.
// Result channel (out_valid/out_ready): one result per tick with the busy flag,
// the running job's remaining ticks, the pool size, the saturating wait total,
// the overflow flag for a dropped arrival and the finished flag.
// The waiting pool is a row of POOL_DEPTH cells. A minimum search ripples
// through the cells one cell per cycle, so a tick passes through accept, the
// search over all cells and commit; one tick is in work at a time.
// Reset empties the pool, idles the processor and clears tick count and total.
// If the receiver stalls, the finished result is held in the output register;
// the next tick may be accepted and searched meanwhile, and its commit waits
// until the held result is taken.
`default_nettype none
module aging_priority_preemptive_scheduler #(
  parameter int POOL_DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_arrival_valid,
  input  wire logic [aps_pkg::PRIO_W-1:0]           in_job_priority,
  input  wire logic [aps_pkg::LEFT_W-1:0]           in_job_burst,
  input  wire logic                                 in_arrivals_finished,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_busy_res,
  output logic [aps_pkg::LEFT_W-1:0]                out_running_left,
  output logic [$clog2(POOL_DEPTH+1)-1:0]           out_waiting_count,
  output logic [aps_pkg::SUM_W-1:0]                 out_wait_total,
  output logic                                      out_pool_overflow,
  output logic                                      out_finished
);
  import aps_pkg::*;
`include "aging_priority_preemptive_scheduler_defines.svh"

  localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int FILL_W = $clog2(POOL_DEPTH + 1);
  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;

  state_t             st_r, st_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [KEY_W-1:0]   run_key_r, run_key_nxt;
  logic [LEFT_W-1:0]  rem_r, rem_nxt;
  logic               idle_r, idle_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               ovf_r, ovf_nxt;
  logic               done_in_r, done_in_nxt;
  logic               ov_r, ov_nxt;
  logic               ob_r, ob_nxt;
  logic [LEFT_W-1:0]  ol_r, ol_nxt;
  logic [FILL_W-1:0]  oc_r, oc_nxt;
  logic [SUM_W-1:0]   os_r, os_nxt;
  logic               oo_r, oo_nxt;
  logic               of_r, of_nxt;

  logic               accept, commit, append_arr, disp, pre, idle_a;
  logic [SUM_W:0]     sum_wide;
  logic [LEFT_W-1:0]  rem_mid;
  entry_t             arr_ent, old_ent;

  best_t              best_chain [0:POOL_DEPTH];
  logic [IDX_W-1:0]   idx_chain  [0:POOL_DEPTH];
  entry_t             ents       [0:POOL_DEPTH-1];
  best_t              best;
  logic [IDX_W-1:0]   best_idx;

  assign in_ready   = (st_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign commit     = (st_r == S_APPLY) && (!ov_r || out_ready);
  assign append_arr = accept && in_arrival_valid && (fill_r < FILL_W'(POOL_DEPTH));
  assign arr_ent    = '{key: KEY_W'(in_job_priority) + KEY_W'(tick_r), left: in_job_burst};
  assign old_ent    = '{key: run_key_r, left: rem_r};
  assign best       = best_chain[POOL_DEPTH];
  assign best_idx   = idx_chain[POOL_DEPTH];

  assign best_chain[0] = '0;
  assign idx_chain[0]  = '0;

  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    logic   live, wr_en;
    entry_t wr_data;
    entry_t nbr;

    if (i + 1 < POOL_DEPTH) begin : g_nbr
      assign nbr = ents[i+1];
    end else begin : g_last
      assign nbr = ents[i];
    end

    assign live = (FILL_W'(i) < fill_r);

    // arrival appends at the fill slot; shift down above the dispatched entry, preempted job lands at the end
    always_comb begin
      wr_en   = 1'b0;
      wr_data = arr_ent;
      if (append_arr && fill_r == FILL_W'(i)) begin
        wr_en = 1'b1;
      end else if (commit && disp) begin
        if (pre && fill_r == FILL_W'(i + 1)) begin
          wr_en   = 1'b1;
          wr_data = old_ent;
        end else if (IDX_W'(i) >= best_idx && FILL_W'(i + 1) < fill_r) begin
          wr_en   = 1'b1;
          wr_data = nbr;
        end
      end
    end

    aps_cell #(.IDX_W(IDX_W), .CELL_IDX(i)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .live         (live),
      .wr_en        (wr_en),
      .wr_data      (wr_data),
      .best_in      (best_chain[i]),
      .best_idx_in  (idx_chain[i]),
      .ent          (ents[i]),
      .best_out     (best_chain[i+1]),
      .best_idx_out (idx_chain[i+1])
    );
  end

  always_comb begin
    idle_a = idle_r;
    pre    = 1'b0;
    if (!idle_r) begin
      if (rem_r == '0) begin
        idle_a = 1'b1;
      end else if (fill_r != '0 && best.key < run_key_r) begin
        pre    = 1'b1;
        idle_a = 1'b1;
      end
    end
    disp = idle_a && (fill_r != '0);
  end

  always_comb begin
    st_nxt      = st_r;
    cnt_nxt     = cnt_r;
    fill_nxt    = fill_r;
    run_key_nxt = run_key_r;
    rem_nxt     = rem_r;
    idle_nxt    = idle_r;
    tick_nxt    = tick_r;
    sum_nxt     = sum_r;
    ovf_nxt     = ovf_r;
    done_in_nxt = done_in_r;
    ov_nxt      = ov_r && !out_ready;
    ob_nxt      = ob_r;
    ol_nxt      = ol_r;
    oc_nxt      = oc_r;
    os_nxt      = os_r;
    oo_nxt      = oo_r;
    of_nxt      = of_r;
    rem_mid     = rem_r;
    sum_wide    = '0;
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          st_nxt      = S_SCAN;
          cnt_nxt     = '0;
          ovf_nxt     = in_arrival_valid && !append_arr;
          done_in_nxt = in_arrivals_finished;
          if (append_arr) begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      S_SCAN: begin
        // wait here while the search ripples through every cell
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(POOL_DEPTH - 1)) begin
          st_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (commit) begin
          st_nxt = S_IDLE;
          if (disp) begin
            run_key_nxt = best.key;
            rem_mid     = best.left;
            idle_nxt    = 1'b0;
            if (!pre) begin
              fill_nxt = fill_r - 1'b1;
            end
          end else begin
            idle_nxt = idle_a;
          end
          if (!(disp || !idle_a) || rem_mid == '0) begin
            rem_nxt = '0;
          end else begin
            rem_nxt = rem_mid - 1'b1;
          end
          sum_wide = {1'b0, sum_r} + (SUM_W+1)'(fill_nxt);
          sum_nxt  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
          if (tick_r != TICK_MAX) begin
            tick_nxt = tick_r + 1'b1;
          end
          ov_nxt = 1'b1;
          ob_nxt = !idle_nxt;
          ol_nxt = rem_nxt;
          oc_nxt = fill_nxt;
          os_nxt = sum_nxt;
          oo_nxt = ovf_r;
          of_nxt = idle_nxt && (fill_nxt == '0) && done_in_r;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    ovf_r     <= ovf_nxt;
    done_in_r <= done_in_nxt;
    ob_r      <= ob_nxt;
    ol_r      <= ol_nxt;
    oc_r      <= oc_nxt;
    os_r      <= os_nxt;
    oo_r      <= oo_nxt;
    of_r      <= of_nxt;
    if (!rst_n) begin
      st_r      <= S_IDLE;
      fill_r    <= '0;
      idle_r    <= 1'b1;
      tick_r    <= '0;
      sum_r     <= '0;
      ov_r      <= 1'b0;
      run_key_r <= '0;
      rem_r     <= '0;
    end else begin
      st_r      <= st_nxt;
      fill_r    <= fill_nxt;
      idle_r    <= idle_nxt;
      tick_r    <= tick_nxt;
      sum_r     <= sum_nxt;
      ov_r      <= ov_nxt;
      run_key_r <= run_key_nxt;
      rem_r     <= rem_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_busy_res      = ob_r;
  assign out_running_left  = ol_r;
  assign out_waiting_count = oc_r;
  assign out_wait_total    = os_r;
  assign out_pool_overflow = oo_r;
  assign out_finished      = of_r;

  `APS_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= FILL_W'(POOL_DEPTH), "pool fill beyond depth")
  `APS_ASSERT_IMP(a_idle_no_left, ov_r && !ob_r, ol_r == '0, "idle result with ticks left")
  `APS_ASSERT_NXT(a_accept_scan, accept, st_r == S_SCAN && !in_ready, "tick not searched")
  `APS_ASSERT_IMP(a_idle_rem, idle_r, rem_r == '0, "idle processor with remaining ticks")
endmodule
`default_nettype wire

>>> verif/aging_priority_preemptive_scheduler_test.sv
`default_nettype none
module aging_priority_preemptive_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [aps_pkg::SUM_W-1:0] TOTAL_MAX = '1;
  localparam logic [aps_pkg::TICK_W-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic                        arrive;
    logic [aps_pkg::PRIO_W-1:0]  prio;
    logic [aps_pkg::LEFT_W-1:0]  burst;
    logic                        no_more;
  } tick_t;

  typedef struct packed {
    logic                        busy;
    logic [aps_pkg::LEFT_W-1:0]  left;
    logic [CNT_W-1:0]            waiting;
    logic [aps_pkg::SUM_W-1:0]   total;
    logic                        overflow;
    logic                        done;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_arrival_valid = 1'b0;
  logic [aps_pkg::PRIO_W-1:0] in_job_priority = '0;
  logic [aps_pkg::LEFT_W-1:0] in_job_burst = '0;
  logic in_arrivals_finished = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_busy_res;
  logic [aps_pkg::LEFT_W-1:0] out_running_left;
  logic [CNT_W-1:0] out_waiting_count;
  logic [aps_pkg::SUM_W-1:0] out_wait_total;
  logic out_pool_overflow;
  logic out_finished;

  aging_priority_preemptive_scheduler #(.POOL_DEPTH(DEPTH)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler shadow state
  logic [aps_pkg::KEY_W-1:0]  wait_key[DEPTH];
  logic [aps_pkg::LEFT_W-1:0] wait_left[DEPTH];
  int                         wait_fill;
  logic [aps_pkg::KEY_W-1:0]  run_key;
  logic [16:0]                run_left;
  logic                       cpu_idle;
  logic [aps_pkg::TICK_W-1:0] now_tick;
  logic [aps_pkg::SUM_W-1:0]  total_sum;

  tick_t   pending_ticks[$];
  status_t expected_status[$];
  int      errors = 0;
  int      send_idle_pct = 9;
  int      recv_idle_pct = 54;
  bit      hold_off = 1'b0;
  // input transfer seen at the last rising edge
  bit      in_done = 1'b0;

  function automatic int best_waiting();
    int b;
    b = 0;
    for (int i = 1; i < wait_fill; i++)
      if (wait_key[i] < wait_key[b]) b = i;
    return b;
  endfunction

  task automatic pool_push(input logic [aps_pkg::KEY_W-1:0] k, input logic [15:0] l);
    if (wait_fill < DEPTH) begin
      wait_key[wait_fill] = k;
      wait_left[wait_fill] = l;
      wait_fill++;
    end
  endtask

  task automatic schedule_tick(input tick_t t);
    status_t s;
    logic ovf, preempt;
    logic [aps_pkg::KEY_W-1:0] old_key;
    logic [15:0] old_left;
    int b;
    ovf = 1'b0;
    preempt = 1'b0;
    old_key = run_key;
    old_left = run_left[15:0];
    if (t.arrive) begin
      if (wait_fill < DEPTH) pool_push({18'd0, t.prio} + {2'd0, now_tick}, t.burst);
      else ovf = 1'b1;
    end
    if (!cpu_idle) begin
      if (run_left == 0) cpu_idle = 1'b1;
      else if (wait_fill > 0 && wait_key[best_waiting()] < run_key) begin
        preempt = 1'b1;
        cpu_idle = 1'b1;
      end
    end
    if (cpu_idle && wait_fill > 0) begin
      b = best_waiting();
      run_key = wait_key[b];
      run_left = {1'b0, wait_left[b]};
      for (int i = b; i + 1 < wait_fill; i++) begin
        wait_key[i] = wait_key[i+1];
        wait_left[i] = wait_left[i+1];
      end
      wait_fill--;
      cpu_idle = 1'b0;
      if (preempt) pool_push(old_key, old_left);
    end
    if (TOTAL_MAX - total_sum < aps_pkg::SUM_W'(wait_fill)) total_sum = TOTAL_MAX;
    else total_sum = total_sum + aps_pkg::SUM_W'(wait_fill);
    if (!cpu_idle && run_left > 0) run_left--;
    if (cpu_idle) run_left = '0;
    if (now_tick != TICK_MAX) now_tick++;
    s.busy = !cpu_idle;
    s.left = run_left[15:0];
    s.waiting = CNT_W'(wait_fill);
    s.total = total_sum;
    s.overflow = ovf;
    s.done = cpu_idle && wait_fill == 0 && t.no_more;
    expected_status = {expected_status, s};
  endtask

  function automatic tick_t make_tick(bit arr, int p, int bu, bit fin);
    tick_t t;
    t.arrive = arr;
    t.prio = aps_pkg::PRIO_W'(p);
    t.burst = aps_pkg::LEFT_W'(bu);
    t.no_more = fin;
    return t;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_done) begin
        // hold until transfer
      end else if (!hold_off && pending_ticks.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        tick_t t;
        t = pending_ticks.pop_front();
        in_valid <= 1'b1;
        in_arrival_valid <= t.arrive;
        in_job_priority <= t.prio;
        in_job_burst <= t.burst;
        in_arrivals_finished <= t.no_more;
      end else begin
        in_valid <= 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      in_done <= in_valid && in_ready;
      if (in_valid && in_ready)
        schedule_tick(make_tick(in_arrival_valid, in_job_priority, in_job_burst,
                                in_arrivals_finished));
      if (out_valid && out_ready) begin
        status_t got, exp_s;
        got = '{out_busy_res, out_running_left, out_waiting_count, out_wait_total,
                out_pool_overflow, out_finished};
        if (expected_status.size() == 0) begin
          errors++;
          $display("%0t unexpected result transfer: %p", $realtime, got);
        end else begin
          exp_s = expected_status.pop_front();
          if (got !== exp_s) begin
            errors++;
            $display("%0t mismatch: expected %p actual %p", $realtime, exp_s, got);
          end
        end
      end
    end
  end

  task automatic drain();
    wait (pending_ticks.size() == 0);
    while (in_valid || expected_status.size() > 0) @(posedge clk);
  endtask

  task automatic add_random(int n);
    int p, bu;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: p = 16'hffff;
        1: p = 0;
        default: p = $urandom_range(60);
      endcase
      case ($urandom_range(19))
        0: bu = $urandom;
        1: bu = 0;
        default: bu = $urandom_range(12);
      endcase
      pending_ticks = {pending_ticks, make_tick($urandom_range(99) < 55, p & 16'hffff,
                                                bu & 16'hffff, $urandom_range(9) == 0)};
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      wait_key[i] = '0;
      wait_left[i] = '0;
    end
    wait_fill = 0;
    run_key = '0;
    run_left = '0;
    cpu_idle = 1'b1;
    now_tick = '0;
    total_sum = '0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: extremes, preemption, ties, overflow with a full pool
    pending_ticks = {pending_ticks, make_tick(0, 0, 0, 1)};
    pending_ticks = {pending_ticks, make_tick(1, 16'hffff, 16'hffff, 0)};
    pending_ticks = {pending_ticks, make_tick(1, 0, 3, 0)};
    pending_ticks = {pending_ticks, make_tick(1, 5, 0, 0)};
    pending_ticks = {pending_ticks, make_tick(1, 5, 2, 0)};
    for (int i = 0; i < 17; i++)
      pending_ticks = {pending_ticks, make_tick(1, 16'h5555 ^ i, 16'haaaa, i[0])};
    pending_ticks = {pending_ticks, make_tick(1, 0, 1, 1)};
    pending_ticks = {pending_ticks, make_tick(0, 16'hffff, 16'hffff, 1)};
    drain();

    // pause until everything has come back
    hold_off = 1'b1;
    repeat (30) @(posedge clk);
    hold_off = 1'b0;

    add_random(200);
    drain();
    send_idle_pct = 54;
    recv_idle_pct = 9;
    add_random(200);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(200);
    drain();
    repeat (DEPTH + 10) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

>>> aging_priority_preemptive_scheduler.f
+incdir+hdl
hdl/aps_pkg.sv
hdl/aps_cell.sv
hdl/aging_priority_preemptive_scheduler.sv
verif/aging_priority_preemptive_scheduler_test.sv
